// ----- hdl/rcmr_pkg.sv -----
// shared constants and action codes for the rod cutting revenue unit
`timescale 1ns / 1ps
package rcmr_pkg;

  localparam int NUM_PIECES_DEF     = 10;
  localparam int MAX_ROD_LENGTH_DEF = 64;

  localparam int ACTION_W = 1;
  localparam int INDEX_W  = 4;
  localparam int PLEN_W   = 7;
  localparam int PRICE_W  = 16;
  localparam int ROD_W    = 7;
  localparam int OUT_W    = 23;
  localparam int REV_W    = 24;

  localparam logic [ACTION_W-1:0] ACT_LOAD  = 1'b0;
  localparam logic [ACTION_W-1:0] ACT_QUERY = 1'b1;

endpackage

// ----- hdl/rod_cutting_max_revenue_unit.sv -----
// Rod cutting best revenue unit: top level with piece table and scan sequencer
//
// Input channel (in_valid / in_stall) carries one item per transfer. A load
// (in_action low) writes one piece entry and completes in the transfer cycle;
// an index beyond the table is dropped. A query (in_action high) asks for the
// best revenue of in_rod_length, saturated to MAX_ROD_LENGTH.
// A query rebuilds the revenue store bottom up with one shared add and
// compare: for each length m it scans the piece entries in order, one memory
// read per piece, until the table ends or an entry is zero or longer than m,
// then writes the best revenue of m. Length 0 skips the scan. in_stall stays
// high until the result sits in the output register.
// Result channel (out_valid / out_stall) gives one transfer per query, none
// per load. The output register lets a new item in while a result waits; if a
// second result is ready before the first is taken, the unit holds it.
// Reset (rst_n low, synchronous) clears the sequencer and the output valid;
// piece table and revenue store are undefined until written, so all pieces
// must be loaded before the first query.
`timescale 1ns / 1ps
module rod_cutting_max_revenue_unit #(
  parameter int NUM_PIECES     = rcmr_pkg::NUM_PIECES_DEF,
  parameter int MAX_ROD_LENGTH = rcmr_pkg::MAX_ROD_LENGTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rcmr_pkg::ACTION_W-1:0] in_action,
  input  logic [rcmr_pkg::INDEX_W-1:0]  in_entry_index,
  input  logic [rcmr_pkg::PLEN_W-1:0]   in_piece_length,
  input  logic [rcmr_pkg::PRICE_W-1:0]  in_piece_price,
  input  logic [rcmr_pkg::ROD_W-1:0]    in_rod_length,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [rcmr_pkg::OUT_W-1:0] out_best_revenue
);
  import rcmr_pkg::*;

  localparam int LW   = $clog2(MAX_ROD_LENGTH + 1);
  localparam int PIW  = (NUM_PIECES > 1) ? $clog2(NUM_PIECES) : 1;
  localparam int CW   = $clog2(NUM_PIECES + 1);
  localparam int CMPW = (LW > PLEN_W) ? LW : PLEN_W;
  localparam int EIW  = (CW > INDEX_W) ? CW : INDEX_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_DONE  = 3'd3;

  logic [PLEN_W-1:0]  plen_r  [NUM_PIECES];
  logic [PRICE_W-1:0] price_r [NUM_PIECES];

  logic [2:0]        state_r, state_nxt;
  logic [LW-1:0]     m_r, m_nxt;
  logic [LW-1:0]     n_r, n_nxt;
  logic [CW-1:0]     i_r, i_nxt;
  logic [REV_W-1:0]  best_r, best_nxt;
  logic              pend_r, pend_nxt;
  logic [PRICE_W-1:0] pprice_r, pprice_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  out_rev_r, out_rev_nxt;

  logic              in_xfer;
  logic              load_xfer;
  logic              query_xfer;
  logic [CMPW-1:0]   rod_ext;
  logic [LW-1:0]     rod_sat;
  logic [PIW-1:0]    pidx;
  logic [CMPW-1:0]   len_ext;
  logic [CMPW-1:0]   m_ext;
  logic [CMPW-1:0]   diff;
  logic              piece_ok;
  logic [REV_W-1:0]  offer;
  logic [REV_W-1:0]  best_cur;

  logic              wr_en;
  logic [LW-1:0]     wr_addr;
  logic [REV_W-1:0]  wr_data;
  logic [LW-1:0]     rd_addr;
  logic [REV_W-1:0]  rd_data;

  assign in_stall   = (state_r != S_IDLE);
  assign in_xfer    = in_valid && !in_stall;
  assign load_xfer  = in_xfer && (in_action == ACT_LOAD);
  assign query_xfer = in_xfer && (in_action == ACT_QUERY);

  assign rod_ext = CMPW'(in_rod_length);
  assign rod_sat = (rod_ext > CMPW'(MAX_ROD_LENGTH)) ? LW'(MAX_ROD_LENGTH) : LW'(in_rod_length);

  // piece table loads
  always_ff @(posedge clk) begin
    if (load_xfer && (EIW'(in_entry_index) < EIW'(NUM_PIECES))) begin
      plen_r[PIW'(in_entry_index)]  <= in_piece_length;
      price_r[PIW'(in_entry_index)] <= in_piece_price;
    end
  end

  // current piece under scan; past the table it is never used
  assign pidx     = PIW'(i_r);
  assign len_ext  = CMPW'(plen_r[pidx]);
  assign m_ext    = CMPW'(m_r);
  assign diff     = m_ext - len_ext;
  assign piece_ok = (i_r != CW'(NUM_PIECES)) && (len_ext != '0) && (len_ext <= m_ext);

  // shared add and compare; price is unsigned, stored revenue signed
  assign offer    = REV_W'(pprice_r) + rd_data;
  assign best_cur = (pend_r && ($signed(offer) > $signed(best_r))) ? offer : best_r;

  always_comb begin
    state_nxt     = state_r;
    m_nxt         = m_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    best_nxt      = best_r;
    pend_nxt      = 1'b0;
    pprice_nxt    = pprice_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_rev_nxt   = out_rev_r;
    wr_en         = 1'b0;
    wr_addr       = m_r;
    wr_data       = best_r;
    rd_addr       = LW'(diff);
    unique case (state_r)
      S_IDLE: begin
        if (query_xfer) begin
          // revenue of length 0 is zero
          wr_en   = 1'b1;
          wr_addr = '0;
          wr_data = '0;
          n_nxt   = rod_sat;
          m_nxt   = LW'(1);
          i_nxt   = '0;
          if (rod_sat == '0) begin
            best_nxt  = '0;
            state_nxt = S_DONE;
          end else begin
            best_nxt  = '1;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        best_nxt = best_cur;
        if (piece_ok) begin
          pend_nxt   = 1'b1;
          pprice_nxt = price_r[pidx];
          i_nxt      = i_r + CW'(1);
        end else begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        wr_en = 1'b1;
        if (m_r == n_r) begin
          state_nxt = S_DONE;
        end else begin
          m_nxt     = m_r + LW'(1);
          i_nxt     = '0;
          best_nxt  = '1;
          state_nxt = S_SCAN;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_rev_nxt   = best_r[OUT_W-1:0];
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r       <= m_nxt;
    n_r       <= n_nxt;
    i_r       <= i_nxt;
    best_r    <= best_nxt;
    pprice_r  <= pprice_nxt;
    out_rev_r <= out_rev_nxt;
  end

  rcmr_rev_mem #(
    .DEPTH (MAX_ROD_LENGTH + 1),
    .AW    (LW)
  ) u_rev_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_valid        = out_valid_r;
  assign out_best_revenue = $signed(out_rev_r);

endmodule

// ----- hdl/rcmr_rev_mem.sv -----
// revenue store: one write port, one read port with registered read data
`timescale 1ns / 1ps
module rcmr_rev_mem #(
  parameter int DEPTH = 65,
  parameter int AW    = 7
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [rcmr_pkg::REV_W-1:0] wr_data,
  input  logic [AW-1:0]              rd_addr,
  output logic [rcmr_pkg::REV_W-1:0] rd_data
);
  import rcmr_pkg::*;

  logic [REV_W-1:0] mem [DEPTH];
  logic [REV_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
